@@ sv/table_leaf_record_parser_unit_defines.svh @@
// Assertion macros for the table leaf record parser
`ifndef TABLE_LEAF_RECORD_PARSER_UNIT_DEFINES_SVH
`define TABLE_LEAF_RECORD_PARSER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TLRP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define TLRP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/tlrp_pkg.sv @@
// Shared types and constants for the table leaf record parser
`timescale 1ns / 1ps
package tlrp_pkg;

	localparam int MAX_COLS_DEF   = 32;
	localparam int PAGE_BYTES_DEF = 65536;

	localparam logic [3:0] K_ROWID   = 4'd0;
	localparam logic [3:0] K_NULL    = 4'd1;
	localparam logic [3:0] K_INT     = 4'd2;
	localparam logic [3:0] K_TEXT    = 4'd3;
	localparam logic [3:0] K_TBYTE   = 4'd4;
	localparam logic [3:0] K_BLOB    = 4'd5;
	localparam logic [3:0] K_UNKNOWN = 4'd6;
	localparam logic [3:0] K_TRUNC   = 4'd7;
	localparam logic [3:0] K_ERROR   = 4'd8;
	localparam logic [3:0] K_END     = 4'd9;

	typedef enum logic [2:0] {
		PH_IDLE, PH_PAYLOAD, PH_ROWID, PH_HDRSIZE, PH_SERIAL, PH_INT, PH_TEXT, PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		B_ITEM, B_RD, B_EV, B_ERR
	} bstate_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        start;
		logic [16:0] avail;
		logic [7:0]  data;
	} item_t;

endpackage

@@ sv/tlrp_front.sv @@
// Front end: accepts input transfers, clamps the byte budget and queues items
`timescale 1ns / 1ps
module tlrp_front import tlrp_pkg::*; #(
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [16:0] bytes_available,
	input  logic [7:0]  data_byte,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	localparam logic [16:0] PageLim = 17'(PAGE_BYTES);

	item_t       ent_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push;
	item_t       nitem;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	always_comb begin
		nitem.start = !opcode;
		nitem.avail = (bytes_available > PageLim) ? PageLim : bytes_available;
		nitem.data  = data_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= nitem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

@@ sv/tlrp_core.sv @@
// Back end: record parser state machine, serial type store and result register
`timescale 1ns / 1ps
`include "table_leaf_record_parser_unit_defines.svh"
module tlrp_core import tlrp_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [4:0]  column,
	output logic [63:0] value,
	output logic        last
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam logic [5:0] MaxC = 6'(MAX_COLS);

	function automatic logic [63:0] field_bytes(input logic [63:0] s);
		logic [63:0] r;
		if (s >= 64'd12) begin
			r = (s - 64'd12) >> 1;
		end else begin
			case (s[3:0])
				4'd1: r = 64'd1;
				4'd2: r = 64'd2;
				4'd3: r = 64'd3;
				4'd4: r = 64'd4;
				4'd5: r = 64'd6;
				4'd6, 4'd7: r = 64'd8;
				default: r = 64'd0;
			endcase
		end
		return r;
	endfunction

	function automatic logic [63:0] sext(input logic [63:0] a, input logic [3:0] n);
		logic [63:0] r;
		case (n)
			4'd1: r = {{56{a[7]}}, a[7:0]};
			4'd2: r = {{48{a[15]}}, a[15:0]};
			4'd3: r = {{40{a[23]}}, a[23:0]};
			4'd4: r = {{32{a[31]}}, a[31:0]};
			4'd6: r = {{16{a[47]}}, a[47:0]};
			default: r = a;
		endcase
		return r;
	endfunction

	logic [63:0] st_mem [MAX_COLS];
	logic [63:0] rd_q;

	phase_t      phase_q, phase_n;
	bstate_t     bs_q, bs_n;
	logic [63:0] acc_q, acc_n;
	logic [3:0]  vcnt_q, vcnt_n;
	logic [16:0] bl_q, bl_n;
	logic [16:0] hdr_q, hdr_n;
	logic [5:0]  cc_q, cc_n;
	logic [5:0]  cur_q, cur_n;
	logic [16:0] cleft_q, cleft_n;
	logic [3:0]  isz_q, isz_n;

	logic        ofree, emit, elast;
	logic [3:0]  ekind;
	logic [5:0]  ecol;
	logic [63:0] evalue;
	logic        mem_we, rd_en;
	logic        do_ns;

	logic [63:0] vacc, sz;
	logic        vdone;
	logic [3:0]  vcnt1;
	logic [16:0] bl1, hdr1, cleft1;
	logic [7:0]  b;

	assign ofree = !out_valid || !out_stall;
	assign b     = q_item.data;

	always_comb begin
		if (vcnt_q < 4'd8) begin
			vacc  = {acc_q[56:0], b[6:0]};
			vdone = !b[7];
		end else begin
			vacc  = {acc_q[55:0], b};
			vdone = 1'b1;
		end
		vcnt1  = vcnt_q + 4'd1;
		bl1    = (bl_q != 17'd0) ? bl_q - 17'd1 : bl_q;
		hdr1   = (hdr_q != 17'd0) ? hdr_q - 17'd1 : hdr_q;
		cleft1 = (cleft_q != 17'd0) ? cleft_q - 17'd1 : cleft_q;
		sz     = field_bytes(rd_q);
	end

	always_comb begin
		phase_n = phase_q;
		bs_n    = bs_q;
		acc_n   = acc_q;
		vcnt_n  = vcnt_q;
		bl_n    = bl_q;
		hdr_n   = hdr_q;
		cc_n    = cc_q;
		cur_n   = cur_q;
		cleft_n = cleft_q;
		isz_n   = isz_q;
		emit    = 1'b0;
		ekind   = K_ERROR;
		ecol    = 6'd0;
		evalue  = 64'd0;
		elast   = 1'b0;
		mem_we  = 1'b0;
		rd_en   = 1'b0;
		do_ns   = 1'b0;
		q_pop   = 1'b0;
		case (bs_q)
			B_ITEM: begin
				if (q_valid && ofree) begin
					q_pop = 1'b1;
					if (q_item.start) begin
						acc_n   = 64'd0;
						vcnt_n  = 4'd0;
						hdr_n   = 17'd0;
						cc_n    = 6'd0;
						cur_n   = 6'd0;
						cleft_n = 17'd0;
						bl_n    = q_item.avail;
						if (q_item.avail == 17'd0) begin
							emit  = 1'b1;
							elast = 1'b1;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end else if (phase_q != PH_IDLE) begin
						bl_n = bl1;
						case (phase_q)
							PH_PAYLOAD, PH_ROWID: begin
								acc_n  = vacc;
								vcnt_n = vcnt1;
								if (!vdone) begin
									if (bl1 == 17'd0) begin
										emit  = 1'b1;
										elast = 1'b1;
									end
								end else if (phase_q == PH_ROWID) begin
									emit   = 1'b1;
									ekind  = K_ROWID;
									evalue = vacc;
									if (bl1 == 17'd0) begin
										bs_n = B_ERR;
									end else begin
										phase_n = PH_HDRSIZE;
										acc_n   = 64'd0;
										vcnt_n  = 4'd0;
									end
								end else if (bl1 == 17'd0) begin
									emit  = 1'b1;
									elast = 1'b1;
								end else begin
									phase_n = PH_ROWID;
									acc_n   = 64'd0;
									vcnt_n  = 4'd0;
								end
							end
							PH_HDRSIZE: begin
								acc_n  = vacc;
								vcnt_n = vcnt1;
								if (!vdone) begin
									if (bl1 == 17'd0) begin
										emit  = 1'b1;
										elast = 1'b1;
									end
								end else if (vacc > ({47'd0, bl1} + {60'd0, vcnt1})) begin
									emit  = 1'b1;
									elast = 1'b1;
								end else begin
									hdr_n = (vacc > {60'd0, vcnt1}) ?
										17'(vacc - {60'd0, vcnt1}) : 17'd0;
									cc_n  = 6'd0;
									do_ns = 1'b1;
								end
							end
							PH_SERIAL: begin
								hdr_n  = hdr1;
								acc_n  = vacc;
								vcnt_n = vcnt1;
								if (!vdone) begin
									if (bl1 == 17'd0) begin
										cur_n = 6'd0;
										bs_n  = B_RD;
									end
								end else begin
									mem_we = (cc_q < MaxC);
									cc_n   = cc_q + 6'd1;
									do_ns  = 1'b1;
								end
							end
							default: begin
								if (phase_q == PH_INT) acc_n = {acc_q[55:0], b};
								if (phase_q == PH_TEXT) begin
									emit   = 1'b1;
									ekind  = K_TBYTE;
									ecol   = cur_q;
									evalue = {56'd0, b};
								end
								cleft_n = cleft1;
								if (cleft1 == 17'd0) begin
									if (phase_q == PH_INT) begin
										emit   = 1'b1;
										ekind  = K_INT;
										ecol   = cur_q;
										evalue = sext({acc_q[55:0], b}, isz_q);
									end
									cur_n = cur_q + 6'd1;
									bs_n  = B_RD;
								end
							end
						endcase
					end
				end
			end
			B_RD: begin
				if (cur_q < cc_q && cur_q < MaxC) begin
					rd_en = 1'b1;
					bs_n  = B_EV;
				end else if (ofree) begin
					emit  = 1'b1;
					ekind = K_END;
					ecol  = cc_q;
					elast = 1'b1;
					bs_n  = B_ITEM;
				end
			end
			B_EV: begin
				if (ofree) begin
					ecol = cur_q;
					if (sz > {47'd0, bl_q}) begin
						emit  = 1'b1;
						ekind = K_TRUNC;
						elast = 1'b1;
						bs_n  = B_ITEM;
					end else if (rd_q == 64'd0) begin
						emit  = 1'b1;
						ekind = K_NULL;
						cur_n = cur_q + 6'd1;
						bs_n  = B_RD;
					end else if (rd_q == 64'd8 || rd_q == 64'd9) begin
						emit   = 1'b1;
						ekind  = K_INT;
						evalue = rd_q - 64'd8;
						cur_n  = cur_q + 6'd1;
						bs_n   = B_RD;
					end else if (rd_q >= 64'd1 && rd_q <= 64'd6) begin
						phase_n = PH_INT;
						cleft_n = 17'(sz);
						isz_n   = 4'(sz);
						acc_n   = 64'd0;
						vcnt_n  = 4'd0;
						bs_n    = B_ITEM;
					end else begin
						emit = 1'b1;
						if (rd_q >= 64'd12) begin
							ekind  = rd_q[0] ? K_TEXT : K_BLOB;
							evalue = sz;
						end else begin
							ekind = K_UNKNOWN;
						end
						if (sz != 64'd0) begin
							phase_n = (rd_q >= 64'd12 && rd_q[0]) ? PH_TEXT : PH_SKIP;
							cleft_n = 17'(sz);
							bs_n    = B_ITEM;
						end else begin
							cur_n = cur_q + 6'd1;
							bs_n  = B_RD;
						end
					end
				end
			end
			B_ERR: begin
				if (ofree) begin
					emit  = 1'b1;
					elast = 1'b1;
					bs_n  = B_ITEM;
				end
			end
			default: bs_n = B_ITEM;
		endcase

		if (do_ns) begin
			if (hdr_n != 17'd0 && bl_n != 17'd0) begin
				if (cc_n >= MaxC) begin
					emit  = 1'b1;
					ekind = K_ERROR;
					ecol  = cc_n;
					elast = 1'b1;
				end else begin
					phase_n = PH_SERIAL;
					acc_n   = 64'd0;
					vcnt_n  = 4'd0;
				end
			end else begin
				cur_n = 6'd0;
				bs_n  = B_RD;
			end
		end

		if (emit && elast) phase_n = PH_IDLE;
	end

	always_ff @(posedge clk) begin
		if (mem_we) st_mem[cc_q[AW-1:0]] <= vacc;
		if (rd_en) rd_q <= st_mem[cur_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bs_q    <= B_ITEM;
			acc_q   <= 64'd0;
			vcnt_q  <= 4'd0;
			bl_q    <= 17'd0;
			hdr_q   <= 17'd0;
			cc_q    <= 6'd0;
			cur_q   <= 6'd0;
			cleft_q <= 17'd0;
			isz_q   <= 4'd0;
			out_valid <= 1'b0;
		end else begin
			phase_q <= phase_n;
			bs_q    <= bs_n;
			acc_q   <= acc_n;
			vcnt_q  <= vcnt_n;
			bl_q    <= bl_n;
			hdr_q   <= hdr_n;
			cc_q    <= cc_n;
			cur_q   <= cur_n;
			cleft_q <= cleft_n;
			isz_q   <= isz_n;
			if (emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind   <= ekind;
			column <= ecol[4:0];
			value  <= evalue;
			last   <= elast;
		end
	end

	`TLRP_ASSERT_IMP(a_cc_range, 1'b1, cc_q <= MaxC, "column count beyond limit")
	`TLRP_ASSERT_NXT(a_last_idle, emit && elast, phase_q == PH_IDLE, "phase not idle after last")
	`TLRP_ASSERT_IMP(a_ev_after_rd, bs_q == B_EV,
		$past(bs_q) == B_RD || $past(bs_q) == B_EV, "evaluate without read")
	`TLRP_ASSERT_IMP(a_content_left,
		bs_q == B_ITEM && (phase_q == PH_INT || phase_q == PH_TEXT || phase_q == PH_SKIP),
		cleft_q != 17'd0, "content phase with nothing left")

endmodule

@@ sv/table_leaf_record_parser_unit.sv @@
// Top level of the table leaf record parser
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | opcode, bytes_available, data_byte
//  out     | output    | out_valid / out_stall| kind, column, value, last
// The back end takes a byte item only while it is not walking columns and the output register
// is free; a two-entry queue parts it from the front. Column walk after the header or a content
// run handles each column as a registered read of the serial type store, then evaluation.
// Every result goes through one output register; a stall there holds the back end.
// Reset is asynchronous, active low, and leaves the parser idle.
`timescale 1ns / 1ps
module table_leaf_record_parser_unit import tlrp_pkg::*; #(
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [16:0] bytes_available,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [4:0]  column,
	output logic [63:0] value,
	output logic        last
);

	logic  q_valid, q_pop;
	item_t q_item;

	tlrp_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .bytes_available, .data_byte,
		.q_valid, .q_item, .q_pop
	);

	tlrp_core #(.MAX_COLS(MAX_COLS)) u_core (
		.clk, .arst_n, .q_valid, .q_item, .q_pop,
		.out_valid, .out_stall, .kind, .column, .value, .last
	);

endmodule
